// ===== hdl/ctt_pkg.sv =====
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared types, character codes and scan-step functions of the
// configuration text tokenizer.
// ----------------------------------------------------------------------------
package ctt_pkg;

  localparam int LINE_BITS_DEF = 16;
  localparam int OUT_LINE_W    = 16;
  localparam int MAX_RES       = 3;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_PLAIN,
    MODE_DQ,
    MODE_SQ,
    MODE_NEEDSP,
    MODE_COMMENT
  } mode_t;

  typedef enum logic [2:0] {
    KIND_BYTE,
    KIND_TOKEN_END,
    KIND_STMT_END,
    KIND_BLOCK_START,
    KIND_BLOCK_END,
    KIND_ERROR,
    KIND_INPUT_END
  } kind_t;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = " ";
  localparam logic [7:0] CH_DQUOTE = "\"";
  localparam logic [7:0] CH_SQUOTE = "'";
  localparam logic [7:0] CH_BSLASH = "\\";
  localparam logic [7:0] CH_HASH   = "#";
  localparam logic [7:0] CH_DOLLAR = "$";
  localparam logic [7:0] CH_SEMI   = ";";
  localparam logic [7:0] CH_LBRACE = "{";
  localparam logic [7:0] CH_RBRACE = "}";
  localparam logic [7:0] CH_T      = "t";
  localparam logic [7:0] CH_R      = "r";
  localparam logic [7:0] CH_N      = "n";
  localparam logic [7:0] NO_BYTE   = 8'h00;

  typedef struct packed {
    mode_t mode;
    logic  skip_next;
    logic  after_dollar;
    logic  pending_backslash;
  } scan_t;

  localparam scan_t SCAN_RESET = '{MODE_IDLE, 1'b0, 1'b0, 1'b0};

  typedef struct packed {
    logic [1:0]                count;
    logic [MAX_RES-1:0][2:0]   kind;
    logic [MAX_RES-1:0][7:0]   data;
  } res_t;

  typedef struct packed {
    scan_t scan;
    res_t  res;
  } step_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic step_t put(step_t st, kind_t k, logic [7:0] b);
    step_t r;
    r = st;
    if (r.res.count != 2'(MAX_RES)) begin
      r.res.kind[r.res.count] = k;
      r.res.data[r.res.count] = b;
      r.res.count             = r.res.count + 2'd1;
    end
    return r;
  endfunction

  // escape decoding of raw token text
  function automatic step_t raw_byte(step_t st, logic [7:0] c);
    step_t r;
    logic  done;
    r    = st;
    done = 1'b0;
    if (r.scan.pending_backslash) begin
      r.scan.pending_backslash = 1'b0;
      done = 1'b1;
      if ((c == CH_DQUOTE) || (c == CH_SQUOTE) || (c == CH_BSLASH)) begin
        r = put(r, KIND_BYTE, c);
      end else if (c == CH_T) begin
        r = put(r, KIND_BYTE, CH_TAB);
      end else if (c == CH_R) begin
        r = put(r, KIND_BYTE, CH_CR);
      end else if (c == CH_N) begin
        r = put(r, KIND_BYTE, CH_LF);
      end else begin
        r = put(r, KIND_BYTE, CH_BSLASH);
        done = 1'b0;
      end
    end
    if (!done) begin
      if (c == CH_BSLASH) begin
        r.scan.pending_backslash = 1'b1;
      end else begin
        r = put(r, KIND_BYTE, c);
      end
    end
    return r;
  endfunction

  function automatic step_t token_end(step_t st);
    step_t r;
    r = st;
    if (r.scan.pending_backslash) begin
      r.scan.pending_backslash = 1'b0;
      r = put(r, KIND_BYTE, CH_BSLASH);
    end
    r = put(r, KIND_TOKEN_END, NO_BYTE);
    r.scan.skip_next    = 1'b0;
    r.scan.after_dollar = 1'b0;
    return r;
  endfunction

  function automatic step_t in_token(step_t st, logic [7:0] c);
    step_t      r;
    logic [7:0] q;
    r = st;
    q = (r.scan.mode == MODE_DQ) ? CH_DQUOTE : CH_SQUOTE;
    if (r.scan.skip_next) begin
      r.scan.skip_next = 1'b0;
      r = raw_byte(r, c);
    end else if ((c == CH_LBRACE) && r.scan.after_dollar) begin
      r = raw_byte(r, c);
    end else begin
      r.scan.after_dollar = 1'b0;
      if (c == CH_BSLASH) begin
        r = raw_byte(r, c);
        r.scan.skip_next = 1'b1;
      end else if (c == CH_DOLLAR) begin
        r = raw_byte(r, c);
        r.scan.after_dollar = 1'b1;
      end else if ((r.scan.mode == MODE_DQ) || (r.scan.mode == MODE_SQ)) begin
        if (c == q) begin
          r = token_end(r);
          r.scan.mode = MODE_NEEDSP;
        end else begin
          r = raw_byte(r, c);
        end
      end else if (is_space(c)) begin
        r = token_end(r);
        r.scan.mode = MODE_IDLE;
      end else if (c == CH_SEMI) begin
        r = token_end(r);
        r = put(r, KIND_STMT_END, NO_BYTE);
        r.scan.mode = MODE_IDLE;
      end else if (c == CH_LBRACE) begin
        r = token_end(r);
        r = put(r, KIND_BLOCK_START, NO_BYTE);
        r.scan.mode = MODE_IDLE;
      end else begin
        r = raw_byte(r, c);
      end
    end
    return r;
  endfunction

  function automatic step_t between_tokens(step_t st, logic [7:0] c);
    step_t r;
    r = st;
    if (!is_space(c)) begin
      r.scan.skip_next         = 1'b0;
      r.scan.after_dollar      = 1'b0;
      r.scan.pending_backslash = 1'b0;
      case (c)
        CH_SEMI:   r = put(r, KIND_STMT_END, NO_BYTE);
        CH_LBRACE: r = put(r, KIND_BLOCK_START, NO_BYTE);
        CH_RBRACE: r = put(r, KIND_BLOCK_END, NO_BYTE);
        CH_HASH:   r.scan.mode = MODE_COMMENT;
        CH_BSLASH: begin
          r.scan.mode      = MODE_PLAIN;
          r.scan.skip_next = 1'b1;
        end
        CH_DQUOTE: r.scan.mode = MODE_DQ;
        CH_SQUOTE: r.scan.mode = MODE_SQ;
        CH_DOLLAR: begin
          r.scan.mode = MODE_PLAIN;
          r = raw_byte(r, c);
          r.scan.after_dollar = 1'b1;
        end
        default: begin
          r.scan.mode = MODE_PLAIN;
          r = raw_byte(r, c);
        end
      endcase
    end
    return r;
  endfunction

endpackage

// ===== hdl/ctt_lexer.sv =====
// ----------------------------------------------------------------------------
// ctt_lexer
// Scan state and line counter, with the combinational step that turns one
// text byte into up to three results.
// ----------------------------------------------------------------------------
module ctt_lexer #(
  parameter int LINE_BITS = ctt_pkg::LINE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic [7:0]                        char_in,
  input  logic                              end_of_input,
  output ctt_pkg::res_t                     res,
  output logic [ctt_pkg::OUT_LINE_W-1:0]    line_number
);

  ctt_pkg::scan_t         scan;
  ctt_pkg::step_t         step;
  logic [LINE_BITS-1:0]   line_count;
  logic [LINE_BITS-1:0]   line_count_next;

  always_comb begin
    step.scan = scan;
    step.res  = '0;
    if (end_of_input) begin
      step.scan = ctt_pkg::SCAN_RESET;
      step = ctt_pkg::put(step, ctt_pkg::KIND_INPUT_END, ctt_pkg::NO_BYTE);
    end else begin
      case (scan.mode)
        ctt_pkg::MODE_COMMENT: begin
          if (char_in == ctt_pkg::CH_LF) step.scan.mode = ctt_pkg::MODE_IDLE;
        end
        ctt_pkg::MODE_NEEDSP: begin
          step.scan.mode = ctt_pkg::MODE_IDLE;
          if (ctt_pkg::is_space(char_in)) begin
            step = step;
          end else if (char_in == ctt_pkg::CH_SEMI) begin
            step = ctt_pkg::put(step, ctt_pkg::KIND_STMT_END, ctt_pkg::NO_BYTE);
          end else if (char_in == ctt_pkg::CH_LBRACE) begin
            step = ctt_pkg::put(step, ctt_pkg::KIND_BLOCK_START, ctt_pkg::NO_BYTE);
          end else begin
            step = ctt_pkg::put(step, ctt_pkg::KIND_ERROR, ctt_pkg::NO_BYTE);
          end
        end
        ctt_pkg::MODE_PLAIN, ctt_pkg::MODE_DQ, ctt_pkg::MODE_SQ: begin
          step = ctt_pkg::in_token(step, char_in);
        end
        default: begin
          step.scan.mode = ctt_pkg::MODE_IDLE;
          step = ctt_pkg::between_tokens(step, char_in);
        end
      endcase
    end
  end

  // saturating line feed count
  always_comb begin
    line_count_next = line_count;
    if (!end_of_input && (char_in == ctt_pkg::CH_LF) && (line_count != '1)) begin
      line_count_next = line_count + LINE_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan       <= ctt_pkg::SCAN_RESET;
      line_count <= LINE_BITS'(1);
    end else if (accept) begin
      scan       <= step.scan;
      line_count <= line_count_next;
    end
  end

  assign res         = step.res;
  assign line_number = ctt_pkg::OUT_LINE_W'(line_count_next);

endmodule

// ===== hdl/ctt_result_buf.sv =====
// ----------------------------------------------------------------------------
// ctt_result_buf
// Output register holding the results of one byte and handing them out
// one transfer at a time.
// ----------------------------------------------------------------------------
module ctt_result_buf (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  ctt_pkg::res_t                     res,
  input  logic [ctt_pkg::OUT_LINE_W-1:0]    line_in,
  output logic                              can_load,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        kind,
  output logic [7:0]                        byte_out,
  output logic [ctt_pkg::OUT_LINE_W-1:0]    line_number,
  output logic                              last
);

  logic [1:0]                            count;
  logic [ctt_pkg::MAX_RES-1:0][2:0]      kinds;
  logic [ctt_pkg::MAX_RES-1:0][7:0]      datas;
  logic [ctt_pkg::OUT_LINE_W-1:0]        line;
  logic                                  pop;

  assign pop      = (count != 2'd0) && out_ready;
  assign can_load = (count == 2'd0) || ((count == 2'd1) && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= res.count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kinds <= res.kind;
      datas <= res.data;
      line  <= line_in;
    end else if (pop) begin
      for (int i = 0; i < ctt_pkg::MAX_RES - 1; i++) begin
        kinds[i] <= kinds[i+1];
        datas[i] <= datas[i+1];
      end
    end
  end

  assign out_valid   = (count != 2'd0);
  assign last        = (count == 2'd1);
  assign kind        = kinds[0];
  assign byte_out    = datas[0];
  assign line_number = line;

endmodule

// ===== hdl/config_text_tokenizer.sv =====
// ----------------------------------------------------------------------------
// config_text_tokenizer
// Streaming lexer for brace-structured configuration text.
// ----------------------------------------------------------------------------
// One text byte is taken per cycle unless the input is stalled, and scanned in the same
// cycle; its results (none to three) appear from the output register in the next cycle,
// one per transfer. A byte that gives more than one result keeps the input stalled while
// the output register drains to its last result, so the input runs at one byte per cycle
// as long as each byte gives at most one result and the output keeps up.
// ----------------------------------------------------------------------------
module config_text_tokenizer #(
  parameter int LINE_BITS = ctt_pkg::LINE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_in
  input  logic [0:0]  s_tuser,   // end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // kind[2:0], byte_out[10:3], line_number[26:11]
  output logic        m_tlast
);

  ctt_pkg::res_t                    res;
  logic [ctt_pkg::OUT_LINE_W-1:0]   line_step;
  logic [ctt_pkg::OUT_LINE_W-1:0]   line_out;
  logic [2:0]                       kind;
  logic [7:0]                       byte_out;
  logic                             accept;

  assign accept = s_tvalid && s_tready;

  ctt_lexer #(
    .LINE_BITS (LINE_BITS)
  ) u_lexer (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .char_in      (s_tdata),
    .end_of_input (s_tuser[0]),
    .res          (res),
    .line_number  (line_step)
  );

  ctt_result_buf u_result_buf (
    .clk         (clk),
    .rst         (rst),
    .load        (accept),
    .res         (res),
    .line_in     (line_step),
    .can_load    (s_tready),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .kind        (kind),
    .byte_out    (byte_out),
    .line_number (line_out),
    .last        (m_tlast)
  );

  assign m_tdata = {5'b0, line_out, byte_out, kind};

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the configuration text tokenizer. Text bytes go in
// over the input stream, and a behavioural scanner kept in step with the
// accepted bytes predicts every token byte and event. A check on the output
// stream compares each result, field by field, with the oldest prediction.
// A short directed script comes first. Random statements, quoted strings,
// comments and noise follow under several idle and stall mixes. Last, a burst
// of line feeds exercises the line counter.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_W = 16;

  typedef struct packed {
    ctt_pkg::kind_t    kind;
    logic [7:0]        data;
    logic [LINE_W-1:0] line;
    logic              last;
  } lex_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // char_in
  logic [0:0]  s_tuser = 1'b0;    // end_of_input
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;           // kind[2:0], byte_out[10:3], line_number[26:11]
  logic        m_tlast;

  config_text_tokenizer #(.LINE_BITS(LINE_W)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // scanner copy used for prediction
  ctt_pkg::mode_t    lex_mode;
  bit                lex_skip;
  bit                lex_after_dollar;
  bit                lex_pending_bs;
  logic [LINE_W-1:0] lex_line;
  lex_result_t       step_out[$];
  lex_result_t       expected_results[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int items_sent     = 0;
  int eoi_sent       = 0;
  int results_seen   = 0;
  int kind_tally[7];

  function automatic bit is_blank(logic [7:0] c);
    return (c == ctt_pkg::CH_SPACE) || (c == ctt_pkg::CH_TAB) ||
           (c == ctt_pkg::CH_CR) || (c == ctt_pkg::CH_LF);
  endfunction

  function automatic void add_result(ctt_pkg::kind_t k, logic [7:0] b);
    lex_result_t r;
    if (step_out.size() < ctt_pkg::MAX_RES) begin
      r.kind = k;
      r.data = b;
      r.line = '0;
      r.last = 1'b0;
      step_out.push_back(r);
    end
  endfunction

  // escape decoding of token text
  function automatic void decode_text(logic [7:0] c);
    if (lex_pending_bs) begin
      lex_pending_bs = 1'b0;
      case (c)
        ctt_pkg::CH_DQUOTE, ctt_pkg::CH_SQUOTE, ctt_pkg::CH_BSLASH: begin
          add_result(ctt_pkg::KIND_BYTE, c);
          return;
        end
        ctt_pkg::CH_T: begin
          add_result(ctt_pkg::KIND_BYTE, ctt_pkg::CH_TAB);
          return;
        end
        ctt_pkg::CH_R: begin
          add_result(ctt_pkg::KIND_BYTE, ctt_pkg::CH_CR);
          return;
        end
        ctt_pkg::CH_N: begin
          add_result(ctt_pkg::KIND_BYTE, ctt_pkg::CH_LF);
          return;
        end
        default: add_result(ctt_pkg::KIND_BYTE, ctt_pkg::CH_BSLASH);
      endcase
    end
    if (c == ctt_pkg::CH_BSLASH) lex_pending_bs = 1'b1;
    else add_result(ctt_pkg::KIND_BYTE, c);
  endfunction

  function automatic void close_token();
    if (lex_pending_bs) begin
      lex_pending_bs = 1'b0;
      add_result(ctt_pkg::KIND_BYTE, ctt_pkg::CH_BSLASH);
    end
    add_result(ctt_pkg::KIND_TOKEN_END, ctt_pkg::NO_BYTE);
    lex_skip         = 1'b0;
    lex_after_dollar = 1'b0;
  endfunction

  function automatic void token_char(logic [7:0] c);
    logic [7:0] quote;
    quote = (lex_mode == ctt_pkg::MODE_DQ) ? ctt_pkg::CH_DQUOTE : ctt_pkg::CH_SQUOTE;
    if (lex_skip) begin
      lex_skip = 1'b0;
      decode_text(c);
      return;
    end
    if ((c == ctt_pkg::CH_LBRACE) && lex_after_dollar) begin
      decode_text(c);
      return;
    end
    lex_after_dollar = 1'b0;
    if (c == ctt_pkg::CH_BSLASH) begin
      decode_text(c);
      lex_skip = 1'b1;
    end else if (c == ctt_pkg::CH_DOLLAR) begin
      decode_text(c);
      lex_after_dollar = 1'b1;
    end else if ((lex_mode == ctt_pkg::MODE_DQ) || (lex_mode == ctt_pkg::MODE_SQ)) begin
      if (c == quote) begin
        close_token();
        lex_mode = ctt_pkg::MODE_NEEDSP;
      end else begin
        decode_text(c);
      end
    end else if (is_blank(c)) begin
      close_token();
      lex_mode = ctt_pkg::MODE_IDLE;
    end else if (c == ctt_pkg::CH_SEMI) begin
      close_token();
      add_result(ctt_pkg::KIND_STMT_END, ctt_pkg::NO_BYTE);
      lex_mode = ctt_pkg::MODE_IDLE;
    end else if (c == ctt_pkg::CH_LBRACE) begin
      close_token();
      add_result(ctt_pkg::KIND_BLOCK_START, ctt_pkg::NO_BYTE);
      lex_mode = ctt_pkg::MODE_IDLE;
    end else begin
      decode_text(c);
    end
  endfunction

  function automatic void idle_char(logic [7:0] c);
    if (is_blank(c)) return;
    lex_skip         = 1'b0;
    lex_after_dollar = 1'b0;
    lex_pending_bs   = 1'b0;
    case (c)
      ctt_pkg::CH_SEMI:   add_result(ctt_pkg::KIND_STMT_END, ctt_pkg::NO_BYTE);
      ctt_pkg::CH_LBRACE: add_result(ctt_pkg::KIND_BLOCK_START, ctt_pkg::NO_BYTE);
      ctt_pkg::CH_RBRACE: add_result(ctt_pkg::KIND_BLOCK_END, ctt_pkg::NO_BYTE);
      ctt_pkg::CH_HASH:   lex_mode = ctt_pkg::MODE_COMMENT;
      ctt_pkg::CH_BSLASH: begin
        lex_mode = ctt_pkg::MODE_PLAIN;
        lex_skip = 1'b1;
      end
      ctt_pkg::CH_DQUOTE: lex_mode = ctt_pkg::MODE_DQ;
      ctt_pkg::CH_SQUOTE: lex_mode = ctt_pkg::MODE_SQ;
      ctt_pkg::CH_DOLLAR: begin
        lex_mode = ctt_pkg::MODE_PLAIN;
        decode_text(c);
        lex_after_dollar = 1'b1;
      end
      default: begin
        lex_mode = ctt_pkg::MODE_PLAIN;
        decode_text(c);
      end
    endcase
  endfunction

  function automatic void predict_item(logic [7:0] c, logic eoi);
    step_out.delete();
    if (eoi) begin
      lex_mode         = ctt_pkg::MODE_IDLE;
      lex_skip         = 1'b0;
      lex_after_dollar = 1'b0;
      lex_pending_bs   = 1'b0;
      add_result(ctt_pkg::KIND_INPUT_END, ctt_pkg::NO_BYTE);
    end else begin
      if ((c == ctt_pkg::CH_LF) && (lex_line != '1)) lex_line = lex_line + LINE_W'(1);
      case (lex_mode)
        ctt_pkg::MODE_COMMENT: if (c == ctt_pkg::CH_LF) lex_mode = ctt_pkg::MODE_IDLE;
        ctt_pkg::MODE_NEEDSP: begin
          lex_mode = ctt_pkg::MODE_IDLE;
          if (!is_blank(c)) begin
            if (c == ctt_pkg::CH_SEMI) begin
              add_result(ctt_pkg::KIND_STMT_END, ctt_pkg::NO_BYTE);
            end else if (c == ctt_pkg::CH_LBRACE) begin
              add_result(ctt_pkg::KIND_BLOCK_START, ctt_pkg::NO_BYTE);
            end else begin
              add_result(ctt_pkg::KIND_ERROR, ctt_pkg::NO_BYTE);
            end
          end
        end
        ctt_pkg::MODE_PLAIN, ctt_pkg::MODE_DQ, ctt_pkg::MODE_SQ: token_char(c);
        default: begin
          lex_mode = ctt_pkg::MODE_IDLE;
          idle_char(c);
        end
      endcase
    end
    foreach (step_out[i]) begin
      step_out[i].line = lex_line;
      step_out[i].last = (i == step_out.size() - 1);
      expected_results.push_back(step_out[i]);
    end
  endfunction

  task automatic send_item(input logic [7:0] c, input logic eoi);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tuser  <= eoi;
    do @(posedge clk); while (!s_tready);
    predict_item(c, eoi);
    items_sent++;
    if (eoi) eoi_sent++;
  endtask

  task automatic send_char(input logic [7:0] c);
    send_item(c, 1'b0);
  endtask

  task automatic wait_for_results();
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    while ((expected_results.size() != 0) && (guard < 20000)) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  // output side: random stalls and the result check
  task automatic check_transfer();
    lex_result_t want;
    results_seen++;
    if (m_tdata[2:0] < 3'd7) kind_tally[m_tdata[2:0]]++;
    if (expected_results.size() == 0) begin
      error_count++;
      if (error_count <= 10)
        $display("unexpected transfer: kind %0d byte %02h line %0d last %0b",
                 m_tdata[2:0], m_tdata[10:3], m_tdata[26:11], m_tlast);
      return;
    end
    want = expected_results.pop_front();
    if ((m_tdata[2:0] !== want.kind) || (m_tdata[10:3] !== want.data) ||
        (m_tdata[26:11] !== want.line) || (m_tlast !== want.last)) begin
      error_count++;
      if (error_count <= 10)
        $display("mismatch: want kind %0d byte %02h line %0d last %0b, got %0d %02h %0d %0b",
                 want.kind, want.data, want.line, want.last,
                 m_tdata[2:0], m_tdata[10:3], m_tdata[26:11], m_tlast);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_transfer();
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // random text helpers
  function automatic logic [7:0] pick_text_char();
    case ($urandom_range(11))
      6:  return 8'($urandom_range("9", "0"));
      7:  return ctt_pkg::CH_DOLLAR;
      8:  return ctt_pkg::CH_BSLASH;
      9:  return ctt_pkg::CH_LBRACE;
      10: begin
        case ($urandom_range(3))
          0: return ctt_pkg::CH_RBRACE;
          1: return ctt_pkg::CH_HASH;
          2: return ctt_pkg::CH_DQUOTE;
          default: return ctt_pkg::CH_SQUOTE;
        endcase
      end
      11: return 8'($urandom_range(255));
      default: return 8'($urandom_range("z", "a"));
    endcase
  endfunction

  function automatic logic [7:0] pick_escape_char();
    case ($urandom_range(8))
      0: return ctt_pkg::CH_T;
      1: return ctt_pkg::CH_R;
      2: return ctt_pkg::CH_N;
      3: return ctt_pkg::CH_DQUOTE;
      4: return ctt_pkg::CH_SQUOTE;
      5: return ctt_pkg::CH_BSLASH;
      6: return ctt_pkg::CH_DOLLAR;
      7: return ctt_pkg::CH_LBRACE;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_text_char(input logic [7:0] c);
    send_char(c);
    if (c == ctt_pkg::CH_BSLASH) send_char(pick_escape_char());
  endtask

  task automatic send_plain_token();
    int n;
    n = $urandom_range(6, 1);
    repeat (n) send_text_char(pick_text_char());
    case ($urandom_range(5))
      0: send_char(ctt_pkg::CH_SPACE);
      1: send_char(ctt_pkg::CH_TAB);
      2: send_char(ctt_pkg::CH_CR);
      3: send_char(ctt_pkg::CH_LF);
      4: send_char(ctt_pkg::CH_SEMI);
      default: send_char(ctt_pkg::CH_LBRACE);
    endcase
  endtask

  task automatic send_quoted_token();
    logic [7:0] quote;
    logic [7:0] c;
    int         n;
    quote = $urandom_range(1) ? ctt_pkg::CH_DQUOTE : ctt_pkg::CH_SQUOTE;
    n     = $urandom_range(6);
    send_char(quote);
    repeat (n) begin
      c = pick_text_char();
      if (c == quote) send_char(ctt_pkg::CH_BSLASH);
      send_text_char(c);
    end
    send_char(quote);
    case ($urandom_range(5))
      0: send_char(ctt_pkg::CH_SPACE);
      1: send_char(ctt_pkg::CH_SEMI);
      2: send_char(ctt_pkg::CH_LBRACE);
      3: send_char(ctt_pkg::CH_LF);
      4: send_char(ctt_pkg::CH_CR);
      default: send_char(8'($urandom_range(255)));
    endcase
  endtask

  task automatic send_comment();
    int n;
    n = $urandom_range(5);
    send_char(ctt_pkg::CH_HASH);
    repeat (n) send_char(8'($urandom_range(255)));
    send_char(ctt_pkg::CH_LF);
  endtask

  // tests
  task automatic test_directed_cases();
    logic [7:0] script[$] = '{8'h00, 8'hFF, ctt_pkg::CH_TAB, ctt_pkg::CH_DOLLAR,
                              ctt_pkg::CH_LBRACE, ctt_pkg::CH_SEMI, ctt_pkg::CH_DQUOTE,
                              ctt_pkg::CH_BSLASH, ctt_pkg::CH_T, ctt_pkg::CH_BSLASH, "k",
                              ctt_pkg::CH_BSLASH, ctt_pkg::CH_DQUOTE, ctt_pkg::CH_DQUOTE,
                              ctt_pkg::CH_SEMI, ctt_pkg::CH_SQUOTE, ctt_pkg::CH_SQUOTE, "a",
                              ctt_pkg::CH_HASH, ctt_pkg::CH_RBRACE, ctt_pkg::CH_LF,
                              ctt_pkg::CH_BSLASH, ctt_pkg::CH_BSLASH, ctt_pkg::CH_LBRACE,
                              ctt_pkg::CH_RBRACE, "q"};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (script[i]) send_char(script[i]);
    send_item(8'hA5, 1'b1);
    wait_for_results();
  endtask

  task automatic test_random_streams(input int idle_pct, input int stall_pct,
                                     input int n_items);
    int start;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = items_sent;
    while (items_sent - start < n_items) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5: send_plain_token();
        6, 7, 8, 9, 10:   send_quoted_token();
        11, 12:           send_comment();
        13:               send_char(ctt_pkg::CH_SEMI);
        14:               send_char(ctt_pkg::CH_LBRACE);
        15:               send_char(ctt_pkg::CH_RBRACE);
        16, 17: repeat ($urandom_range(4, 1)) send_char(8'($urandom_range(255)));
        18:      send_char($urandom_range(1) ? ctt_pkg::CH_SPACE : ctt_pkg::CH_LF);
        default:          send_item(8'($urandom_range(255)), 1'b1);
      endcase
    end
    wait_for_results();
  endtask

  task automatic test_line_count();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (30) send_char(ctt_pkg::CH_LF);
    send_char("x");
    send_char(ctt_pkg::CH_SEMI);
    send_char(ctt_pkg::CH_LF);
    send_char(ctt_pkg::CH_RBRACE);
    wait_for_results();
  endtask

  initial begin
    lex_mode         = ctt_pkg::MODE_IDLE;
    lex_skip         = 1'b0;
    lex_after_dollar = 1'b0;
    lex_pending_bs   = 1'b0;
    lex_line         = 1;
    foreach (kind_tally[i]) kind_tally[i] = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_random_streams(0, 0, 110);
    test_random_streams(58, 0, 110);
    test_random_streams(0, 58, 110);
    test_random_streams(31, 31, 110);
    test_line_count();

    error_count += expected_results.size();
    $display("covered %0d bytes, %0d end-of-input markers, %0d results checked, line %0d",
             items_sent - eoi_sent, eoi_sent, results_seen, lex_line);
    $display("by kind: byte %0d, token end %0d, stmt %0d, open %0d, close %0d, error %0d, eoi %0d",
             kind_tally[0], kind_tally[1], kind_tally[2], kind_tally[3],
             kind_tally[4], kind_tally[5], kind_tally[6]);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
